### sv/piecewise_linear_table_interp_assert.svh
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_ASSERT_SVH

// same-cycle implication
`define PLTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define PLTI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg
// types and codes of the piecewise linear table interpolator
// ----------------------------------------------------------------------------
package plti_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BELOW,
        ST_ABOVE,
        ST_NO_SEG,
        ST_EQUAL
    } status_t;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         entry_index;
        logic signed [31:0] breakpoint;
        logic signed [31:0] entry_value;
        logic signed [31:0] query_x;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        status_t            status;
        logic [5:0]         segment_index;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] bp;
        logic signed [31:0] val;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] x;
        logic signed [31:0] bp;
        logic signed [31:0] bi;
        logic signed [31:0] vp;
        logic signed [31:0] vi;
    } interp_in_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } interp_out_t;

endpackage

### sv/plti_mem.sv
// ----------------------------------------------------------------------------
// plti_mem
// table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module plti_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  plti_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output plti_pkg::entry_t     rd_data
);

    plti_pkg::entry_t mem [DEPTH];
    plti_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/plti_interp.sv
// ----------------------------------------------------------------------------
// plti_interp
// segment arithmetic: differences, magnitudes, product, serial divide, sum
// ----------------------------------------------------------------------------
module plti_interp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plti_pkg::interp_in_t  ctrl_in,
    output plti_pkg::interp_out_t ctrl_out
);

    localparam int DIV_STEPS = 34;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef enum logic [2:0] {
        IDLE,
        ABS,
        MUL,
        INIT,
        DIV,
        SUM
    } state_t;

    state_t             state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               done_reg;
    logic signed [31:0] value_reg;

    logic [32:0]        dx_reg;
    logic [32:0]        dr_reg;
    logic [32:0]        d_reg;
    logic signed [31:0] vp_reg;
    logic [32:0]        a_mag_reg;
    logic [32:0]        b_mag_reg;
    logic [32:0]        d_mag_reg;
    logic               neg_reg;
    logic [65:0]        prod_reg;
    logic [32:0]        rem_reg;
    logic [33:0]        low_reg;
    logic [33:0]        q_reg;
    logic               big_reg;

    logic [33:0]        trial;
    logic [33:0]        trial_diff;
    logic               trial_ge;
    logic [34:0]        q_eff;
    logic [35:0]        vp_ext;
    logic [35:0]        sum;
    logic signed [31:0] sat;

    always_comb
    begin
        trial      = {rem_reg, low_reg[33]};
        trial_diff = trial - {1'b0, d_mag_reg};
        trial_ge   = trial >= {1'b0, d_mag_reg};
        q_eff      = big_reg ? {1'b1, 34'd0} : {1'b0, q_reg};
        vp_ext     = {{4{vp_reg[31]}}, vp_reg};
        sum        = neg_reg ? (vp_ext - {1'b0, q_eff}) : (vp_ext + {1'b0, q_eff});
        if (!sum[35] && (sum[34:31] != 4'b0000))
        begin
            sat = SAT_MAX;
        end
        else if (sum[35] && (sum[34:31] != 4'b1111))
        begin
            sat = SAT_MIN;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == SUM);
            case (state_reg)
                IDLE:
                begin
                    if (ctrl_in.start)
                    begin
                        state_reg <= ABS;
                    end
                end
                ABS:
                begin
                    state_reg <= MUL;
                end
                MUL:
                begin
                    state_reg <= INIT;
                end
                INIT:
                begin
                    step_reg  <= '0;
                    state_reg <= DIV;
                end
                DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= SUM;
                    end
                end
                SUM:
                begin
                    value_reg <= sat;
                    state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            IDLE:
            begin
                if (ctrl_in.start)
                begin
                    dx_reg <= {ctrl_in.x[31], ctrl_in.x} - {ctrl_in.bp[31], ctrl_in.bp};
                    dr_reg <= {ctrl_in.vi[31], ctrl_in.vi} - {ctrl_in.vp[31], ctrl_in.vp};
                    d_reg  <= {ctrl_in.bi[31], ctrl_in.bi} - {ctrl_in.bp[31], ctrl_in.bp};
                    vp_reg <= ctrl_in.vp;
                end
            end
            ABS:
            begin
                a_mag_reg <= dx_reg[32] ? (~dx_reg + 33'd1) : dx_reg;
                b_mag_reg <= dr_reg[32] ? (~dr_reg + 33'd1) : dr_reg;
                d_mag_reg <= d_reg[32] ? (~d_reg + 33'd1) : d_reg;
                neg_reg   <= dx_reg[32] ^ dr_reg[32] ^ d_reg[32];
            end
            MUL:
            begin
                prod_reg <= a_mag_reg * b_mag_reg;
            end
            INIT:
            begin
                // quotient of 2^34 or more always saturates
                big_reg <= {1'b0, prod_reg[65:34]} >= d_mag_reg;
                rem_reg <= {1'b0, prod_reg[65:34]};
                low_reg <= prod_reg[33:0];
                q_reg   <= '0;
            end
            DIV:
            begin
                rem_reg <= trial_ge ? trial_diff[32:0] : trial[32:0];
                low_reg <= {low_reg[32:0], 1'b0};
                q_reg   <= {q_reg[32:0], trial_ge};
            end
            default:
            begin
            end
        endcase
    end

    assign ctrl_out.done  = done_reg;
    assign ctrl_out.value = value_reg;

endmodule

### sv/piecewise_linear_table_interp.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// piecewise linear interpolation over a table of Q16.16 breakpoints and values
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req_word) carries table writes
// (cmd 0) and queries (cmd 1). A write gives no response word and leaves the
// block idle; it also clears the search hint. A query gives one response word on
// rsp_valid / rsp_stall / rsp_word.
// A query scans the table memory forward from the hint at one entry per cycle
// on its single read port, the entry before the hint included. When a segment
// is found, the arithmetic unit computes the result (product, 34-step restoring
// divide, saturating sum), and the FINISH state moves it to the response
// register. req_stall is high until the response word appears.
// A response word waiting under rsp_stall does not block new requests; a
// finished query waits only until the response register is free.
// point_count is written on cfg_wr_en and clamped to 2..TABLE_DEPTH; the user
// must write it only while idle, the block itself does not enforce this. Reset
// clears the hint, sets point_count to 2 and empties the response register; table contents are undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [6:0]       cfg_wr_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  plti_pkg::req_t   req_word,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output plti_pkg::rsp_t   rsp_word
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = IW + 8;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] MIN_C   = CW'(2);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        MATH,
        FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [6:0]          count_reg;
    logic [IW-1:0]       hint_reg, hint_next;
    logic [IW-1:0]       last_reg, last_next;
    logic [IW-1:0]       addr_reg, addr_next;
    logic [IW-1:0]       didx_reg, didx_next;
    logic                dvalid_reg, dvalid_next;
    logic                skip_reg, skip_next;
    plti_pkg::status_t   status_reg, status_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic signed [31:0]  x_reg;
    logic signed [31:0]  prev_bp_reg;
    logic signed [31:0]  prev_val_reg;
    logic signed [31:0]  res_reg;
    plti_pkg::rsp_t      rsp_word_reg;

    plti_pkg::entry_t    wr_entry;
    plti_pkg::entry_t    rd_entry;
    logic                mem_wr_en;
    logic                mem_rd_en;
    plti_pkg::interp_in_t  math_in;
    plti_pkg::interp_out_t math_out;

    logic                req_fire;
    logic                rsp_free;
    logic [CW-1:0]       e_ext;
    logic                e_ok;
    logic [CW-1:0]       pc_ext;
    logic [CW-1:0]       n_ext;
    logic [CW-1:0]       n_minus1;
    logic [CW-1:0]       hint_ext;
    logic [IW-1:0]       start_idx;
    logic [IW-1:0]       first_addr;

    logic signed [31:0]  cur_bp;
    logic signed [31:0]  cur_val;
    logic                x_gt;
    logic                sgn_ok;
    logic                eval;
    logic                at_zero;
    logic                at_last;
    logic                hit_below;
    logic                hit_equal;
    logic                found;
    logic                exhaust;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign e_ext     = CW'(req_word.entry_index);
    assign e_ok      = e_ext < DEPTH_C;
    assign pc_ext    = CW'(count_reg);
    assign n_ext     = (pc_ext < MIN_C) ? MIN_C : ((pc_ext > DEPTH_C) ? DEPTH_C : pc_ext);
    assign n_minus1  = n_ext - CW'(1);
    assign hint_ext  = CW'(hint_reg);
    assign start_idx = ((hint_ext + CW'(1)) >= n_ext) ? '0 : hint_reg;
    assign first_addr = (start_idx == '0) ? '0 : (start_idx - 1'b1);

    assign cur_bp    = rd_entry.bp;
    assign cur_val   = rd_entry.val;
    assign x_gt      = x_reg > cur_bp;
    assign sgn_ok    = !(((cur_val > 0) && (prev_val_reg < 0)) ||
                         ((cur_val < 0) && (prev_val_reg > 0)));
    assign eval      = (state_reg == SCAN) && dvalid_reg && !skip_reg;
    assign at_zero   = (didx_reg == '0);
    assign at_last   = (didx_reg == last_reg);
    assign hit_below = eval && !x_gt && at_zero;
    assign hit_equal = eval && !x_gt && !at_zero && sgn_ok && (cur_bp == prev_bp_reg);
    assign found     = eval && !x_gt && !at_zero && sgn_ok && (cur_bp != prev_bp_reg);
    assign exhaust   = eval && !hit_below && !hit_equal && !found && at_last;

    assign mem_wr_en    = (state_reg == IDLE) && req_fire &&
                          (req_word.cmd == plti_pkg::CMD_WRITE) && e_ok;
    assign mem_rd_en    = (state_reg == SCAN);
    assign wr_entry.bp  = req_word.breakpoint;
    assign wr_entry.val = req_word.entry_value;

    assign math_in.start = found;
    assign math_in.x     = x_reg;
    assign math_in.bp    = prev_bp_reg;
    assign math_in.bi    = cur_bp;
    assign math_in.vp    = prev_val_reg;
    assign math_in.vi    = cur_val;

    plti_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (e_ext[IW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_entry)
    );

    plti_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (math_in),
        .ctrl_out (math_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        hint_next      = hint_reg;
        last_next      = last_reg;
        addr_next      = addr_reg;
        didx_next      = didx_reg;
        dvalid_next    = dvalid_reg;
        skip_next      = skip_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            IDLE:
            begin
                if (req_fire)
                begin
                    if (req_word.cmd == plti_pkg::CMD_WRITE)
                    begin
                        hint_next = '0;
                    end
                    else
                    begin
                        hint_next   = start_idx;
                        addr_next   = first_addr;
                        skip_next   = (start_idx != '0);
                        dvalid_next = 1'b0;
                        last_next   = n_minus1[IW-1:0];
                        state_next  = SCAN;
                    end
                end
            end
            SCAN:
            begin
                addr_next   = addr_reg + 1'b1;
                didx_next   = addr_reg;
                dvalid_next = 1'b1;
                if (dvalid_reg && skip_reg)
                begin
                    skip_next = 1'b0;
                end
                if (hit_below)
                begin
                    status_next = plti_pkg::ST_BELOW;
                    state_next  = FINISH;
                end
                else if (hit_equal)
                begin
                    status_next = plti_pkg::ST_EQUAL;
                    state_next  = FINISH;
                end
                else if (found)
                begin
                    hint_next  = didx_reg;
                    state_next = MATH;
                end
                else if (exhaust)
                begin
                    status_next = x_gt ? plti_pkg::ST_ABOVE : plti_pkg::ST_NO_SEG;
                    state_next  = FINISH;
                end
            end
            MATH:
            begin
                if (math_out.done)
                begin
                    status_next = plti_pkg::ST_OK;
                    state_next  = FINISH;
                end
            end
            FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= 7'd2;
            hint_reg      <= '0;
            last_reg      <= '0;
            addr_reg      <= '0;
            didx_reg      <= '0;
            dvalid_reg    <= 1'b0;
            skip_reg      <= 1'b0;
            status_reg    <= plti_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            last_reg      <= last_next;
            addr_reg      <= addr_next;
            didx_reg      <= didx_next;
            dvalid_reg    <= dvalid_next;
            skip_reg      <= skip_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == IDLE) && req_fire)
        begin
            x_reg <= req_word.query_x;
        end
        if ((state_reg == SCAN) && dvalid_reg)
        begin
            prev_bp_reg  <= cur_bp;
            prev_val_reg <= cur_val;
        end
        if ((state_reg == MATH) && math_out.done)
        begin
            res_reg <= math_out.value;
        end
        if ((state_reg == FINISH) && rsp_free)
        begin
            rsp_word_reg.result_value  <= (status_reg == plti_pkg::ST_OK) ? res_reg : '0;
            rsp_word_reg.status        <= status_reg;
            rsp_word_reg.segment_index <= hint_ext[5:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

### sv/plti_checker.sv
// ----------------------------------------------------------------------------
// plti_checker
// port-level checks of the interpolator, bound to the top level
// ----------------------------------------------------------------------------
`include "piecewise_linear_table_interp_assert.svh"

module plti_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input plti_pkg::req_t req_word,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input plti_pkg::rsp_t rsp_word
);

    logic wr_fire;
    logic qry_fire;

    assign wr_fire  = req_valid && !req_stall && (req_word.cmd == plti_pkg::CMD_WRITE);
    assign qry_fire = req_valid && !req_stall && (req_word.cmd == plti_pkg::CMD_QUERY);

    `PLTI_ASSERT_NXT(a_rsp_valid_holds, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)
    `PLTI_ASSERT_NXT(a_rsp_word_holds, clk, rst_n, rsp_valid && rsp_stall, $stable(rsp_word))
    `PLTI_ASSERT_NXT(a_write_one_cycle, clk, rst_n, wr_fire, !req_stall)
    `PLTI_ASSERT_NXT(a_query_busy, clk, rst_n, qry_fire, req_stall)

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (.*);

### dv/tb_piecewise_linear_table_interp.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interp
// self-checking testbench of the piecewise linear table interpolator
// ----------------------------------------------------------------------------
// A clocked driver sends request words from a backlog that the stimulus
// process fills: table writes and queries. At each accepted request the
// testbench updates its own copy of the table and search hint, and queues
// the response it expects for a query. A clocked monitor compares every
// accepted response word, field by field, with the oldest expectation.
// The run starts with directed tables and queries for the corner cases and
// then goes through phases of random tables with random point counts, queries
// swept along the breakpoints, and random noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interp;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int ONE = 65536;
    localparam int RANDOM_WORDS = 1020;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam longint unsigned QUO_CAP = 64'd1 << 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [6:0] cfg_wr_data = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    plti_pkg::req_t req_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    plti_pkg::rsp_t rsp_word;

    plti_pkg::req_t req_backlog[$];
    plti_pkg::rsp_t interp_results_q[$];

    logic signed [31:0] model_bp [DEPTH];
    logic signed [31:0] model_val [DEPTH];
    logic signed [31:0] stim_bp [DEPTH];
    int search_pos = 0;
    logic [6:0] point_count_reg = 7'd2;

    bit calm = 1'b0;
    int errors = 0;
    int words_queued = 0;
    int cycle_count = 0;

    piecewise_linear_table_interp #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word(req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(Q_MAX))
            v = longint'(Q_MAX);
        else if (v < longint'(Q_MIN))
            v = longint'(Q_MIN);
        return v[31:0];
    endfunction

    function automatic int effective_count(input logic [6:0] c);
        if (c < 7'd2)
            return 2;
        if (int'(c) > DEPTH)
            return DEPTH;
        return int'(c);
    endfunction

    // request driver and interpolation predictor
    always @(posedge clk or negedge rst_n)
    begin
        longint x, bi, bp, vi, vp, dx, dr, dd;
        longint unsigned mdx, mdr, mdd, quo;
        int n, idx;
        bit stop, neg;
        plti_pkg::status_t st;
        plti_pkg::rsp_t want;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                if (req_word.cmd == plti_pkg::CMD_WRITE)
                begin
                    model_bp[req_word.entry_index] = req_word.breakpoint;
                    model_val[req_word.entry_index] = req_word.entry_value;
                    search_pos = 0;
                end
                else
                begin
                    n = effective_count(point_count_reg);
                    x = longint'($signed(req_word.query_x));
                    if (search_pos + 1 >= n)
                        search_pos = 0;
                    want = '0;
                    st = plti_pkg::ST_NO_SEG;
                    stop = 1'b0;
                    idx = search_pos;
                    while (idx < n && !stop)
                    begin
                        bi = longint'(model_bp[idx]);
                        if (x <= bi)
                        begin
                            if (idx == 0)
                            begin
                                st = plti_pkg::ST_BELOW;
                                stop = 1'b1;
                            end
                            else
                            begin
                                bp = longint'(model_bp[idx - 1]);
                                vi = longint'(model_val[idx]);
                                vp = longint'(model_val[idx - 1]);
                                if ((vi >= 0 && vp >= 0) || (vi <= 0 && vp <= 0))
                                begin
                                    stop = 1'b1;
                                    if (bi == bp)
                                        st = plti_pkg::ST_EQUAL;
                                    else
                                    begin
                                        dd = bi - bp;
                                        dx = x - bp;
                                        dr = vi - vp;
                                        mdx = (dx < 0) ? -dx : dx;
                                        mdr = (dr < 0) ? -dr : dr;
                                        mdd = (dd < 0) ? -dd : dd;
                                        quo = (mdx * mdr) / mdd;
                                        if (quo > QUO_CAP)
                                            quo = QUO_CAP;
                                        neg = ((dx < 0) != (dr < 0)) != (dd < 0);
                                        want.result_value = clamp32(neg ? vp - longint'(quo)
                                                                        : vp + longint'(quo));
                                        st = plti_pkg::ST_OK;
                                        search_pos = idx;
                                    end
                                end
                            end
                        end
                        if (!stop)
                            idx++;
                    end
                    if (!stop)
                        st = (x > longint'(model_bp[n - 1])) ? plti_pkg::ST_ABOVE
                                                             : plti_pkg::ST_NO_SEG;
                    want.status = st;
                    want.segment_index = 6'(search_pos);
                    interp_results_q.insert(interp_results_q.size(), want);
                end
            end
            if (!req_valid || !req_stall)
            begin
                if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 18))
                begin
                    req_word <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        plti_pkg::rsp_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (interp_results_q.size() == 0)
                begin
                    $error("response word with no query pending");
                    errors++;
                end
                else
                begin
                    want = interp_results_q.pop_front();
                    if (rsp_word.result_value !== want.result_value)
                    begin
                        $error("result_value expected %0d got %0d",
                               $signed(want.result_value), $signed(rsp_word.result_value));
                        errors++;
                    end
                    if (rsp_word.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, rsp_word.status);
                        errors++;
                    end
                    if (rsp_word.segment_index !== want.segment_index)
                    begin
                        $error("segment_index expected %0d got %0d",
                               want.segment_index, rsp_word.segment_index);
                        errors++;
                    end
                end
            end
            rsp_stall <= !calm && ($urandom_range(99) < 18);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_write(input logic [5:0] idx, input logic signed [31:0] b,
                               input logic signed [31:0] v);
        plti_pkg::req_t w;
        w.cmd = plti_pkg::CMD_WRITE;
        w.entry_index = idx;
        w.breakpoint = b;
        w.entry_value = v;
        w.query_x = $urandom;
        req_backlog.insert(req_backlog.size(), w);
        stim_bp[idx] = b;
        words_queued++;
    endtask

    task automatic queue_query(input logic signed [31:0] x);
        plti_pkg::req_t w;
        w.cmd = plti_pkg::CMD_QUERY;
        w.entry_index = 6'($urandom);
        w.breakpoint = $urandom;
        w.entry_value = $urandom;
        w.query_x = x;
        req_backlog.insert(req_backlog.size(), w);
        words_queued++;
    endtask

    // ascending breakpoints with the odd equal or unsorted entry and sign flips
    task automatic build_table(input int n);
        longint b, span, mag;
        int sgn, roll;
        span = ($urandom_range(99) < 25) ? (longint'(1) << 32) / n
                                         : longint'($urandom_range(1, 1 << 18));
        b = (span > (1 << 18)) ? longint'(Q_MIN)
                               : longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        sgn = $urandom_range(1) ? 1 : -1;
        for (int k = 0; k < n; k++)
        begin
            if (k > 0)
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                    b = b;
                else if (roll < 9)
                    b = longint'($signed($urandom));
                else
                    b = b + longint'($urandom_range(1, 32'(span)));
            end
            b = longint'(clamp32(b));
            roll = $urandom_range(99);
            if (roll < 15)
                sgn = -sgn;
            if (roll >= 90)
                mag = longint'($urandom_range(0, 32'h7fff_ffff));
            else if (roll >= 85)
                mag = 0;
            else
                mag = longint'($urandom_range(0, 1 << 22));
            queue_write(6'(k), b[31:0], clamp32(sgn * mag));
        end
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || req_valid || interp_results_q.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_point_count(input logic [6:0] value);
        drain();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        point_count_reg = value;
        @(negedge clk);
    endtask

    initial
    begin
        logic [6:0] cnt;
        longint x;
        int n, nq, j, k, roll, phase;
        bit sweep;
        logic [6:0] clamp_counts [3];
        clamp_counts = '{7'd0, 7'd127, 7'd1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset count of two, hint wrap
        queue_write(6'd0, Q_MIN, 32'sd0);
        queue_write(6'd1, Q_MAX, Q_MAX);
        queue_query(Q_MIN);
        queue_query(32'sd0);
        queue_query(Q_MAX);
        queue_query(-ONE);

        build_table(DEPTH);

        // equal breakpoints, sign changes and a steep segment
        queue_write(6'd0, -100 * ONE, 50 * ONE);
        queue_write(6'd1, -10 * ONE, 5 * ONE);
        queue_write(6'd2, 32'sd0, -(ONE / 2));
        queue_write(6'd3, 32'sd0, -ONE);
        queue_write(6'd4, ONE, ONE);
        queue_write(6'd5, 2 * ONE, -32'sd1);
        queue_write(6'd6, 2 * ONE + 1, Q_MIN);
        queue_write(6'd7, 100 * ONE, 5 * ONE);
        set_point_count(7'd8);
        queue_query(Q_MIN);
        queue_query(-50 * ONE);
        queue_query(-ONE);
        queue_query(ONE / 2);
        queue_query(50 * ONE);
        queue_query(Q_MAX);
        queue_query(2 * ONE + 1);
        queue_query(-100 * ONE);

        foreach (clamp_counts[i])
        begin
            set_point_count(clamp_counts[i]);
            queue_query(-50 * ONE);
            queue_query($urandom);
        end

        phase = 0;
        k = words_queued;
        while (words_queued - k < RANDOM_WORDS)
        begin
            roll = $urandom_range(99);
            if (phase == 0)
                cnt = 7'd64;
            else if (phase == 1)
                cnt = 7'd2;
            else if (roll < 55)
                cnt = 7'($urandom_range(2, 16));
            else if (roll < 70)
                cnt = 7'd64;
            else if (roll < 85)
                cnt = 7'($urandom_range(17, 63));
            else if (roll < 90)
                cnt = 7'($urandom_range(0, 1));
            else
                cnt = 7'($urandom_range(65, 127));
            set_point_count(cnt);
            n = effective_count(cnt);
            calm = (phase >= 6 && phase < 10);
            if (phase == 0 || $urandom_range(99) < 70)
                build_table(n);
            nq = $urandom_range(15, 40);
            sweep = $urandom_range(1);
            j = 0;
            for (int q = 0; q < nq; q++)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                begin
                    queue_write(6'($urandom), $urandom, $urandom);
                    continue;
                end
                if (sweep)
                    j = (j + $urandom_range(0, 1)) % n;
                else
                    j = $urandom_range(0, n - 1);
                roll = $urandom_range(99);
                if (roll < 45)
                    x = longint'(stim_bp[j]) + longint'($urandom_range(0, 1 << 17)) - (1 << 16);
                else if (roll < 60)
                    x = longint'(stim_bp[j]);
                else if (roll < 80)
                    x = (longint'(stim_bp[j]) + longint'(stim_bp[$urandom_range(0, n - 1)])) / 2
                        + longint'($urandom_range(0, 255)) - 128;
                else if (roll < 94)
                    x = longint'($signed($urandom));
                else
                    x = roll[0] ? longint'(Q_MAX) : longint'(Q_MIN);
                queue_query(clamp32(x));
            end
            phase++;
        end
        calm = 1'b0;

        drain();
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
